/* sv/itp_pkg.sv */
// shared types, character codes and precedence table for the infix to postfix converter
package itp_pkg;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef logic [2:0] rank_t;

    localparam rank_t RANK_NONE   = 3'd0;
    localparam rank_t RANK_PAREN  = 3'd1;
    localparam rank_t RANK_ADD    = 3'd2;
    localparam rank_t RANK_MUL    = 3'd4;

    typedef logic [1:0] fault_t;

    localparam fault_t FAULT_NONE      = 2'd0;
    localparam fault_t FAULT_UNMATCHED = 2'd1;
    localparam fault_t FAULT_OVERFLOW  = 2'd2;

    function automatic rank_t rank_of(input logic [7:0] c);
        rank_t r;
        case (c) inside
            CH_PLUS, CH_MINUS:          r = RANK_ADD;
            CH_STAR, CH_SLASH, CH_PCT:  r = RANK_MUL;
            CH_LPAREN:                  r = RANK_PAREN;
            default:                    r = RANK_NONE;
        endcase
        return r;
    endfunction

endpackage

/* sv/infix_to_postfix_converter.sv */
// infix to postfix converter: operator stack with a small pop/push sequencer
// an operand is registered on acceptance and written to the output register from S_OPERAND;
// the input is stalled while a character is worked on: operands pass through S_OPERAND,
//   operators through S_OPPOP then S_PUSH, parentheses through S_PUSH or S_CLOSE; on the last
//   character S_FLUSH pops each entry, then the terminator; any result waits on out_stall
// reset: asynchronous, active low; clears sequencer, stack count and output valid,
//   stack contents are left as they are
module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       expr_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       run_last,
    output logic [1:0] fault
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPERAND,
        S_OPPOP,
        S_PUSH,
        S_CLOSE,
        S_FLUSH
    } state_t;

    state_t         state_reg, state_next;
    logic [7:0]     ch_reg, ch_next;
    logic           last_reg, last_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [7:0]     top_reg, top_next;
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_char_reg, out_char_next;
    logic           run_last_reg, run_last_next;
    fault_t         fault_reg, fault_next;

    logic [7:0]     stack_mem [STACK_DEPTH];

    logic           slot_free;
    logic           push_en;
    logic [7:0]     below_reg;
    logic           has_below;
    logic           stack_full;
    rank_t          ch_rank;
    state_t         done_state;

    assign slot_free  = !out_valid_reg || !out_stall;
    assign has_below  = count_reg > CW'(1);
    assign stack_full = count_reg >= CW'(STACK_DEPTH);
    assign ch_rank    = rank_of(ch_reg);
    assign done_state = last_reg ? S_FLUSH : S_IDLE;

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign run_last  = run_last_reg;
    assign fault     = fault_reg;

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_char_next  = out_char_reg;
        run_last_next  = run_last_reg;
        fault_next     = fault_reg;
        push_en        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next   = in_char;
                    last_next = expr_last;
                    case (in_char) inside
                        CH_LPAREN:                                     state_next = S_PUSH;
                        CH_RPAREN:                                     state_next = S_CLOSE;
                        CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT:  state_next = S_OPPOP;
                        default:                                       state_next = S_OPERAND;
                    endcase
                end
            end
            S_OPERAND:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ch_reg;
                    run_last_next  = !last_reg;
                    fault_next     = FAULT_NONE;
                    state_next     = done_state;
                end
            end
            S_OPPOP:
            begin
                if (count_reg != '0 && rank_of(top_reg) >= ch_rank)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = top_reg;
                        // last result only if the following push succeeds quietly
                        run_last_next  = !last_reg
                                         && !(has_below && rank_of(below_reg) >= ch_rank);
                        fault_next     = FAULT_NONE;
                        top_next       = below_reg;
                        count_next     = count_reg - CW'(1);
                    end
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!stack_full)
                begin
                    push_en    = 1'b1;
                    top_next   = ch_reg;
                    count_next = count_reg + CW'(1);
                    state_next = done_state;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ch_reg;
                    run_last_next  = !last_reg;
                    fault_next     = FAULT_OVERFLOW;
                    state_next     = done_state;
                end
            end
            S_CLOSE:
            begin
                if (count_reg == '0)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = ch_reg;
                        run_last_next  = !last_reg;
                        fault_next     = FAULT_UNMATCHED;
                        state_next     = done_state;
                    end
                end
                else if (top_reg == CH_LPAREN)
                begin
                    // matching open parenthesis is dropped
                    top_next   = below_reg;
                    count_next = count_reg - CW'(1);
                    state_next = done_state;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = top_reg;
                    run_last_next  = !last_reg && has_below && below_reg == CH_LPAREN;
                    fault_next     = FAULT_NONE;
                    top_next       = below_reg;
                    count_next     = count_reg - CW'(1);
                end
            end
            S_FLUSH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    fault_next     = FAULT_NONE;
                    if (count_reg != '0)
                    begin
                        out_char_next = top_reg;
                        run_last_next = 1'b0;
                        top_next      = below_reg;
                        count_next    = count_reg - CW'(1);
                    end
                    else
                    begin
                        out_char_next = CH_NUL;
                        run_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            last_reg      <= 1'b0;
            count_reg     <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            run_last_reg  <= 1'b0;
            fault_reg     <= FAULT_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            run_last_reg  <= run_last_next;
            fault_reg     <= fault_next;
        end
    end

    // entry under the next top is fetched ahead, never the slot being pushed
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            stack_mem[IW'(count_reg)] <= ch_reg;
        end
        below_reg <= stack_mem[IW'(count_next - CW'(2))];
    end

endmodule

/* sv/itp_checker.sv */
// port-level checker for the infix to postfix converter, bound into the converter module
module itp_checker
    import itp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_char,
    input logic       run_last,
    input logic [1:0] fault
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(run_last)
            && $stable(fault))
        else $error("stalled result changed");

    // every accepted transaction keeps the input stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accept");

    a_unmatched_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault == FAULT_UNMATCHED |-> out_char == CH_RPAREN)
        else $error("unmatched fault without close parenthesis");

    a_overflow_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault == FAULT_OVERFLOW |->
            out_char == CH_LPAREN || out_char == CH_PLUS || out_char == CH_MINUS
            || out_char == CH_STAR || out_char == CH_SLASH || out_char == CH_PCT)
        else $error("overflow fault on a character that is never pushed");

    a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fault != 2'd3)
        else $error("undefined fault code");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .run_last  (run_last),
    .fault     (fault)
);

/* bench/testbench.sv */
// testbench for the infix to postfix converter: predicts the postfix stream and checks each result
`timescale 1ns / 100ps

module testbench
    import itp_pkg::*;
();

    localparam int STACK_DEPTH = 16;
    localparam int RESULT_CAP = STACK_DEPTH + 2;
    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        fault_t     flt;
    } postfix_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_char = 8'h00;
    logic       expr_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_char;
    logic       run_last;
    logic [1:0] fault;

    // predictor state
    logic [7:0] op_stack [STACK_DEPTH];
    int         op_depth = 0;
    postfix_t   step_res [$];
    postfix_t   postfix_due [$];

    int  mismatches = 0;
    int  cycles = 0;
    int  stall_left = 0;
    bit  stalls_on = 1'b1;
    bit  gaps_on = 1'b1;

    infix_to_postfix_converter #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_char(in_char),
        .expr_last(expr_last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_char(out_char),
        .run_last(run_last),
        .fault(fault)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     postfix_due.size());
            $display("testbench failed");
            $finish;
        end
    end

    function automatic rank_t prec_of(input logic [7:0] c);
        case (c)
            CH_PLUS, CH_MINUS:         return RANK_ADD;
            CH_STAR, CH_SLASH, CH_PCT: return RANK_MUL;
            CH_LPAREN:                 return RANK_PAREN;
            default:                   return RANK_NONE;
        endcase
    endfunction

    function automatic void emit_out(input logic [7:0] ch, input fault_t flt);
        postfix_t r;
        if (step_res.size() < RESULT_CAP)
        begin
            r.ch = ch;
            r.fin = 1'b0;
            r.flt = flt;
            step_res.push_back(r);
        end
    endfunction

    function automatic void push_op(input logic [7:0] ch);
        if (op_depth < STACK_DEPTH)
        begin
            op_stack[op_depth] = ch;
            op_depth++;
        end
        else
            emit_out(ch, FAULT_OVERFLOW);
    endfunction

    // one accepted character through the shunting-yard rules
    function automatic void shunt_char(input logic [7:0] ch, input logic fin);
        bit found;
        logic [7:0] t;
        step_res.delete();
        if (ch == CH_LPAREN)
            push_op(ch);
        else if (ch == CH_RPAREN)
        begin
            found = 1'b0;
            while (op_depth > 0 && !found)
            begin
                op_depth--;
                t = op_stack[op_depth];
                if (t == CH_LPAREN)
                    found = 1'b1;
                else
                    emit_out(t, FAULT_NONE);
            end
            if (!found)
                emit_out(ch, FAULT_UNMATCHED);
        end
        else if (prec_of(ch) >= RANK_ADD)
        begin
            while (op_depth > 0 && prec_of(op_stack[op_depth - 1]) >= prec_of(ch))
            begin
                op_depth--;
                emit_out(op_stack[op_depth], FAULT_NONE);
            end
            push_op(ch);
        end
        else
            emit_out(ch, FAULT_NONE);

        if (fin)
        begin
            while (op_depth > 0)
            begin
                op_depth--;
                emit_out(op_stack[op_depth], FAULT_NONE);
            end
            emit_out(CH_NUL, FAULT_NONE);
        end

        if (step_res.size() > 0)
            step_res[step_res.size() - 1].fin = 1'b1;
        foreach (step_res[i])
            postfix_due.push_back(step_res[i]);
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // receiver back-pressure: short bursts mostly, a long stall now and then
    always @(posedge clk)
    begin
        int r;
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (!stalls_on)
            out_stall <= 1'b0;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                out_stall <= 1'b0;
                stall_left <= $urandom_range(0, 6);
            end
            else if (r < 93)
            begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(10, 30);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        postfix_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (postfix_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: char %h last %b fault %0d",
                             out_char, run_last, fault);
            end
            else
            begin
                want = postfix_due.pop_front();
                if (want.ch !== out_char || want.fin !== run_last || want.flt !== fault)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%b/%0d got %h/%b/%0d",
                                 want.ch, want.fin, want.flt, out_char, run_last, fault);
                end
            end
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic fin);
        int gap;
        in_valid <= 1'b1;
        in_char <= ch;
        expr_last <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        shunt_char(ch, fin);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off the sender until the output side has caught up
    task automatic wait_for_results();
        if (postfix_due.size() != 0)
        begin
            in_valid <= 1'b0;
            while (postfix_due.size() != 0)
                @(posedge clk);
        end
    endtask

    function automatic logic [7:0] pick_operand();
        logic [7:0] b;
        do
            b = $urandom_range(0, 255);
        while (prec_of(b) != RANK_NONE || b == CH_RPAREN);
        return b;
    endfunction

    task automatic test_operands();
        send_char(CH_NUL, 1'b1);
        send_char(8'hFF, 1'b0);
    endtask

    // every operator, equal and higher precedence pops, unmatched close paren on the last char
    task automatic test_operators();
        send_char(CH_MINUS, 1'b0);
        send_char("b", 1'b0);
        send_char(CH_STAR, 1'b0);
        send_char("c", 1'b0);
        send_char(CH_SLASH, 1'b0);
        send_char(CH_PCT, 1'b0);
        send_char("d", 1'b0);
        send_char(CH_PLUS, 1'b0);
        send_char(CH_RPAREN, 1'b1);
        wait_for_results();
    endtask

    // 17 open parens: the last overflows, then the flush drains a full stack
    task automatic test_overflow();
        repeat (STACK_DEPTH)
            send_char(CH_LPAREN, 1'b0);
        send_char(CH_LPAREN, 1'b1);
        wait_for_results();
    endtask

    task automatic test_random();
        logic [7:0] ops [5];
        logic [8:0] toks [$];
        int sent;
        int phase;
        int open;
        int nterms;
        int j;
        ops[0] = CH_PLUS;
        ops[1] = CH_MINUS;
        ops[2] = CH_STAR;
        ops[3] = CH_SLASH;
        ops[4] = CH_PCT;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase = (sent / 60) % 4;
            gaps_on = phase[0];
            stalls_on = phase[1];
            toks.delete();
            if ($urandom_range(0, 4) == 0)
            begin
                // noise: arbitrary bytes with arbitrary end marks
                repeat ($urandom_range(1, 10))
                    toks.push_back({($urandom_range(0, 5) == 0) ? 1'b1 : 1'b0,
                                    8'($urandom_range(0, 255))});
            end
            else
            begin
                open = 0;
                nterms = $urandom_range(1, 6);
                if ($urandom_range(0, 9) == 0)
                begin
                    open = $urandom_range(12, 18);
                    repeat (open)
                        toks.push_back({1'b0, CH_LPAREN});
                end
                for (int t = 0; t < nterms; t++)
                begin
                    while (open < 4 && $urandom_range(0, 2) == 0)
                    begin
                        toks.push_back({1'b0, CH_LPAREN});
                        open++;
                    end
                    toks.push_back({1'b0, pick_operand()});
                    while (open > 0 && $urandom_range(0, 2) == 0)
                    begin
                        toks.push_back({1'b0, CH_RPAREN});
                        open--;
                    end
                    if (t < nterms - 1)
                        toks.push_back({1'b0, ops[$urandom_range(0, 4)]});
                end
                // sometimes leave an open paren for the flush
                while (open > 0 && $urandom_range(0, 3) != 0)
                begin
                    toks.push_back({1'b0, CH_RPAREN});
                    open--;
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    j = $urandom_range(0, toks.size() - 1);
                    if ($urandom_range(0, 1) == 0)
                        toks[j] = {1'b0, 8'($urandom_range(0, 255))};
                    else
                        toks.insert(j, {1'b0, CH_RPAREN});
                end
                toks[toks.size() - 1][8] = 1'b1;
            end
            foreach (toks[i])
                send_char(toks[i][7:0], toks[i][8]);
            sent += toks.size();
            if ($urandom_range(0, 9) == 0)
                wait_for_results();
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_operands();
        test_operators();
        test_overflow();
        test_random();

        in_valid <= 1'b0;
        while (postfix_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (postfix_due.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", postfix_due.size());
        end
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

/* files.f */
sv/itp_pkg.sv
sv/infix_to_postfix_converter.sv
sv/itp_checker.sv
bench/testbench.sv
